@@ sv/diamb_pkg.sv @@
// Package for the dual image alpha blend unit.
// Holds arithmetic constants, register indexes and the shade and divide-step helpers.
// No dependencies.
package diamb_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned RATIO_W = 10;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned NUM_W   = 2 * PIX_W;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [RATIO_W-1:0] ratio_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [NUM_W-1:0]          num_t;

  typedef enum logic [1:0] {
    REG_FRONT_RATIO = 2'd0,
    REG_BACK_RATIO  = 2'd1
  } reg_index_t;

  localparam ratio_t FRONT_RATIO_RST = 10'sd128;
  localparam ratio_t BACK_RATIO_RST  = -10'sd128;

  // luma weights, percent
  localparam sum_t WEIGHT_R = 15'd30;
  localparam sum_t WEIGHT_G = 15'd59;
  localparam sum_t WEIGHT_B = 15'd11;

  // floor(s / 100) == (s * 20972) >> 21 for s < 25600
  localparam sum_t      RECIP_100   = 15'd20972;
  localparam int unsigned RECIP_SHIFT = 21;

  localparam ratio_t RATIO_MAX = 10'sd256;
  localparam ratio_t RATIO_MIN = -10'sd256;

  localparam pix_t PIX_WHITE = 8'd255;
  localparam pix_t PIX_BLACK = 8'd0;

  localparam int unsigned DIV_STAGES    = 4;
  localparam int unsigned BITS_PER_STEP = PIX_W / DIV_STAGES;

  // floor(p*(256-|q|)/256) + (q > 0 ? q-1 : 0), q saturated to +-256
  function automatic pix_t shade(input pix_t p, input ratio_t q);
    ratio_t          qs;
    logic [8:0]      mag;
    logic [8:0]      scale;
    logic [16:0]     prod;
    logic [8:0]      lift;
    logic [9:0]      v;
    begin
      if (q > RATIO_MAX) begin
        qs = RATIO_MAX;
      end else if (q < RATIO_MIN) begin
        qs = RATIO_MIN;
      end else begin
        qs = q;
      end
      mag   = (qs < 0) ? 9'(-qs) : 9'(qs);
      scale = 9'd256 - mag;
      prod  = 17'(p) * 17'(scale);
      lift  = (qs > 0) ? 9'(qs - 10'sd1) : 9'd0;
      v     = 10'(prod[16:8]) + 10'(lift);
      shade = (v > 10'd255) ? PIX_WHITE : v[7:0];
    end
  endfunction

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [PIX_W:0] div_step(input pix_t rem, input logic nbit,
                                              input pix_t dvs);
    logic [PIX_W:0] t;
    logic [PIX_W:0] d;
    begin
      t = {rem, nbit};
      d = {1'b0, dvs};
      if (t >= d) begin
        div_step = {1'b1, 8'((t - d))};
      end else begin
        div_step = {1'b0, t[PIX_W-1:0]};
      end
    end
  endfunction

endpackage

@@ sv/dual_image_alpha_mirage_blend_unit.sv @@
// Top level of the dual image alpha blend unit: grey, shade, opacity and divide pipeline.
// Depends on diamb_pkg.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   command  | start, busy, front_*, back_*                   | in
//   result   | done, grey_level, opacity                      | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// One pixel pair per clock; each result passes through the stages below in order.
// Stages: luma sums, divide by 100, shade, opacity and dividend, four
// two-bit restoring divide stages for back*255/opacity.
// busy stays low and cfg_ready high; the result side has no back-pressure.
// Synchronous reset clears valid bits and sets the ratio registers to defaults.
module dual_image_alpha_mirage_blend_unit
  import diamb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [7:0]   front_red,
  input  logic [7:0]   front_green,
  input  logic [7:0]   front_blue,
  input  logic         front_present,
  input  logic [7:0]   back_red,
  input  logic [7:0]   back_green,
  input  logic [7:0]   back_blue,
  input  logic         back_present,
  output logic         done,
  output logic [7:0]   grey_level,
  output logic [7:0]   opacity,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [9:0]   cfg_data
);

  ratio_t front_ratio;
  ratio_t back_ratio;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ratio <= FRONT_RATIO_RST;
      back_ratio  <= BACK_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_FRONT_RATIO: front_ratio <= ratio_t'(cfg_data);
        REG_BACK_RATIO:  back_ratio  <= ratio_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // stage 1: weighted sums
  logic s1_valid, s1_fp, s1_bp;
  sum_t s1_fsum, s1_bsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_fp   <= front_present;
    s1_bp   <= back_present;
    s1_fsum <= WEIGHT_R * sum_t'(front_red) + WEIGHT_G * sum_t'(front_green)
             + WEIGHT_B * sum_t'(front_blue);
    s1_bsum <= WEIGHT_R * sum_t'(back_red) + WEIGHT_G * sum_t'(back_green)
             + WEIGHT_B * sum_t'(back_blue);
  end

  // stage 2: divide by 100
  logic        s2_valid, s2_fp, s2_bp;
  pix_t        s2_fgrey, s2_bgrey;
  logic [29:0] f_prod, b_prod;

  assign f_prod = 30'(s1_fsum) * 30'(RECIP_100);
  assign b_prod = 30'(s1_bsum) * 30'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_fp    <= s1_fp;
    s2_bp    <= s1_bp;
    s2_fgrey <= f_prod[RECIP_SHIFT +: PIX_W];
    s2_bgrey <= b_prod[RECIP_SHIFT +: PIX_W];
  end

  // stage 3: shade, absent pixels white or black
  logic s3_valid;
  pix_t s3_front, s3_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_front <= s2_fp ? shade(s2_fgrey, front_ratio) : PIX_WHITE;
    s3_back  <= s2_bp ? shade(s2_bgrey, back_ratio)  : PIX_BLACK;
  end

  // stage 4: opacity and dividend back*255
  logic       s4_valid;
  pix_t       s4_op;
  num_t       s4_num;
  logic [8:0] op_sum;

  assign op_sum = 9'd255 - 9'(s3_front) + 9'(s3_back);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_op  <= op_sum[8] ? PIX_WHITE : op_sum[7:0];
    s4_num <= {s3_back, 8'd0} - num_t'(s3_back);
  end

  // divide stages; quotient never exceeds 255 since back <= opacity
  logic [DIV_STAGES-1:0] d_valid;
  pix_t                  d_rem [DIV_STAGES];
  pix_t                  d_low [DIV_STAGES];
  pix_t                  d_quo [DIV_STAGES];
  pix_t                  d_op  [DIV_STAGES];

  pix_t           in_rem [DIV_STAGES];
  pix_t           in_low [DIV_STAGES];
  pix_t           in_quo [DIV_STAGES];
  pix_t           in_op  [DIV_STAGES];
  logic [PIX_W:0] step_a [DIV_STAGES];
  logic [PIX_W:0] step_b [DIV_STAGES];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        in_rem[k] = s4_num[NUM_W-1:PIX_W];
        in_low[k] = s4_num[PIX_W-1:0];
        in_quo[k] = '0;
        in_op[k]  = s4_op;
      end else begin
        in_rem[k] = d_rem[k-1];
        in_low[k] = d_low[k-1];
        in_quo[k] = d_quo[k-1];
        in_op[k]  = d_op[k-1];
      end
      step_a[k] = div_step(in_rem[k], in_low[k][PIX_W-1], in_op[k]);
      step_b[k] = div_step(step_a[k][PIX_W-1:0], in_low[k][PIX_W-2], in_op[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else begin
      d_valid <= {d_valid[DIV_STAGES-2:0], s4_valid};
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      d_rem[k] <= step_b[k][PIX_W-1:0];
      d_low[k] <= {in_low[k][PIX_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
      d_quo[k] <= {in_quo[k][PIX_W-BITS_PER_STEP-1:0], step_a[k][PIX_W], step_b[k][PIX_W]};
      d_op[k]  <= in_op[k];
    end
  end

  assign done       = d_valid[DIV_STAGES-1];
  assign opacity    = d_op[DIV_STAGES-1];
  assign grey_level = (d_op[DIV_STAGES-1] == PIX_BLACK) ? PIX_BLACK : d_quo[DIV_STAGES-1];

endmodule

@@ test/blend_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the dual image alpha blend unit: tracks ratio writes, predicts
// grey and opacity per accepted pixel pair and compares each strobed result.
// Depends on diamb_pkg.
module blend_checker
  import diamb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] front_red,
  input  logic [7:0] front_green,
  input  logic [7:0] front_blue,
  input  logic       front_present,
  input  logic [7:0] back_red,
  input  logic [7:0] back_green,
  input  logic [7:0] back_blue,
  input  logic       back_present,
  input  logic       done,
  input  logic [7:0] grey_level,
  input  logic [7:0] opacity,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    pix_t grey;
    pix_t alpha;
  } blend_t;

  blend_t blend_q[$];
  ratio_t front_ratio_r = FRONT_RATIO_RST;
  ratio_t back_ratio_r  = BACK_RATIO_RST;
  int     err_n = 0;

  function automatic int luma(input pix_t r, input pix_t g, input pix_t b);
    int s;
    s = 30 * int'(r) + 59 * int'(g) + 11 * int'(b);
    return s / 100;
  endfunction

  function automatic int tone(input int p, input ratio_t q);
    int qq;
    int mag;
    int lift;
    int v;
    qq = int'(q);
    if (qq > 256) qq = 256;
    if (qq < -256) qq = -256;
    mag  = (qq < 0) ? -qq : qq;
    lift = (qq > 0) ? (255 * qq) / 256 : 0;
    v    = (p * (256 - mag)) / 256 + lift;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic blend_t mix_pair();
    int     f;
    int     b;
    int     op;
    int     gr;
    blend_t res;
    f = 255;
    b = 0;
    if (front_present) f = tone(luma(front_red, front_green, front_blue), front_ratio_r);
    if (back_present) b = tone(luma(back_red, back_green, back_blue), back_ratio_r);
    op = 255 - f + b;
    if (op > 255) op = 255;
    if (op == 0) begin
      gr = 0;
    end else begin
      gr = (b * 255) / op;
      if (gr > 255) gr = 255;
    end
    res.grey  = pix_t'(gr);
    res.alpha = pix_t'(op);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      front_ratio_r = FRONT_RATIO_RST;
      back_ratio_r  = BACK_RATIO_RST;
      blend_q.delete();
    end else begin
      // results first: latency keeps them apart from this edge's command
      if (done) begin
        if (blend_q.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("checker: unexpected result grey=%0d opacity=%0d", grey_level, opacity);
        end else begin
          if (grey_level !== blend_q[0].grey || opacity !== blend_q[0].alpha) begin
            err_n++;
            if (err_n <= 10)
              $display("checker: mismatch grey exp %0d got %0d, opacity exp %0d got %0d",
                       blend_q[0].grey, grey_level, blend_q[0].alpha, opacity);
          end
          void'(blend_q.pop_front());
        end
      end
      if (start && !busy) blend_q.push_back(mix_pair());
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRONT_RATIO) front_ratio_r = ratio_t'(cfg_data);
        else if (cfg_index == REG_BACK_RATIO) back_ratio_r = ratio_t'(cfg_data);
      end
    end
    pending    <= blend_q.size();
    fail_count <= err_n;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the blend unit testbench: clock, reset, directed and random pixel pairs,
// ratio programming between phases and the verdict. Depends on diamb_pkg,
// blend_checker and dual_image_alpha_mirage_blend_unit.
module tb_top;
  import diamb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 12;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] front_red = '0;
  logic [7:0] front_green = '0;
  logic [7:0] front_blue = '0;
  logic       front_present = 1'b0;
  logic [7:0] back_red = '0;
  logic [7:0] back_green = '0;
  logic [7:0] back_blue = '0;
  logic       back_present = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  logic       busy;
  logic       done;
  logic [7:0] grey_level;
  logic [7:0] opacity;
  logic       cfg_ready;
  int         fail_count;
  int         pending;
  bit         gaps_on = 1'b1;
  int         cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dual_image_alpha_mirage_blend_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .front_red(front_red), .front_green(front_green), .front_blue(front_blue),
    .front_present(front_present),
    .back_red(back_red), .back_green(back_green), .back_blue(back_blue),
    .back_present(back_present),
    .done(done), .grey_level(grey_level), .opacity(opacity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  blend_checker scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .front_red(front_red), .front_green(front_green), .front_blue(front_blue),
    .front_present(front_present),
    .back_red(back_red), .back_green(back_green), .back_blue(back_blue),
    .back_present(back_present),
    .done(done), .grey_level(grey_level), .opacity(opacity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic pix_t rand_pix();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return pix_t'($urandom_range(255));
  endfunction

  task automatic send_pair(input pix_t fr, input pix_t fg, input pix_t fb, input logic fp,
                           input pix_t br, input pix_t bg, input pix_t bb, input logic bp);
    int gap;
    gap = 0;
    start         <= 1'b1;
    front_red     <= fr;
    front_green   <= fg;
    front_blue    <= fb;
    front_present <= fp;
    back_red      <= br;
    back_green    <= bg;
    back_blue     <= bb;
    back_present  <= bp;
    do @(posedge clk); while (busy);
    while (gaps_on && $urandom_range(99) < 28) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic fp;
    logic bp;
    fp = ($urandom_range(9) < 8) ? 1'b1 : 1'(($urandom_range(1)));
    bp = ($urandom_range(9) < 8) ? 1'b1 : 1'(($urandom_range(1)));
    send_pair(rand_pix(), rand_pix(), rand_pix(), fp, rand_pix(), rand_pix(), rand_pix(), bp);
  endtask

  // let every outstanding transaction complete before touching the ratios
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic program_ratios(input int fq, input int bq);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRONT_RATIO;
    cfg_data  <= 10'(fq);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BACK_RATIO;
    cfg_data  <= 10'(bq);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  int front_set[PHASES] = '{256, -256, 0, 511, -512, -1, 0};
  int back_set[PHASES]  = '{-256, 256, 0, -512, 511, 1, 0};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset ratios
    send_pair(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pair(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pair(rand_pix(), rand_pix(), rand_pix(), 1'b0, rand_pix(), rand_pix(), rand_pix(), 1'b0);
    send_pair(8'hFF, 8'hFF, 8'hFF, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pair(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pair(8'd0, 8'd0, 8'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pair(8'hFF, 8'd0, 8'd0, 1'b1, 8'd0, 8'hFF, 8'd0, 1'b1);
    send_pair(8'd0, 8'hFF, 8'd0, 1'b1, 8'd0, 8'd0, 8'hFF, 1'b1);
    send_pair(8'd0, 8'd0, 8'hFF, 1'b1, 8'hFF, 8'd0, 8'd0, 1'b1);
    send_pair(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pair(8'd0, 8'd0, 8'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pair(8'h55, 8'hAA, 8'h55, 1'b1, 8'hAA, 8'h55, 8'hAA, 1'b1);
    send_pair(8'h80, 8'h80, 8'h80, 1'b1, 8'h7F, 8'h7F, 8'h7F, 1'b1);

    front_set[PHASES-1] = int'($urandom_range(1023));
    back_set[PHASES-1]  = int'($urandom_range(1023));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      program_ratios(front_set[ph], back_set[ph]);
      gaps_on = (ph != 3);
      if (ph == 0) begin
        // saturated ratios: present pixels reach full white front and black back
        send_pair(8'd0, 8'd0, 8'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pair(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
